FILE: rtl/chcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcl_pkg
// Shared types, constants and the CRC round function of the chained
// CRC-hashed table lookup unit.
// ----------------------------------------------------------------------------
package chcl_pkg;

	localparam int DATA_W          = 32;
	localparam int KEY_W           = 32;
	localparam int IDX_W           = 10;
	localparam int SEL_W           = 2;
	localparam int STEP_W          = 2;
	localparam int COUNT_W         = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	localparam int CRC_ROUNDS      = 32;
	localparam int CRC_STEP_ROUNDS = 8;
	localparam int STAGE_REGS      = 2;
	localparam int NUM_CRC         = STAGE_REGS + 1;
	localparam int CRC_PLAIN       = STAGE_REGS;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int HASH_STAGES_DEF = 2;
	localparam int ITEM_Q_DEPTH    = 4;
	localparam int OUT_Q_DEPTH     = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE0_POLY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE1_POLY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE0_SENT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE1_SENT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLAIN_EN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PLAIN_POLY  = 3'd6;

	localparam logic               KIND_LOOKUP  = 1'b0;
	localparam logic               KIND_WRITE   = 1'b1;
	localparam logic [SEL_W-1:0]   SEL_FINAL    = 2'd2;
	localparam logic [STEP_W-1:0]  STEP_FINAL   = 2'd2;
	localparam logic               STATUS_FOUND = 1'b0;
	localparam logic               STATUS_MISS  = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0]                 stage_count;
		logic [STAGE_REGS-1:0][DATA_W-1:0]  stage_poly;
		logic [STAGE_REGS-1:0][DATA_W-1:0]  stage_sentinel;
		logic                               plain_en;
		logic [DATA_W-1:0]                  plain_poly;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic [KEY_W-1:0]   key;
		logic [SEL_W-1:0]   sel;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  val;
		logic               present;
	} in_item_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic                               kind;
		logic [STAGE_REGS-1:0][KEY_W-1:0]   hash;
		logic [STAGE_REGS-1:0]              hash_oor;
		logic [KEY_W-1:0]                   fkey;
		logic                               fkey_oor;
		logic                               wr_ok;
		logic [SEL_W-1:0]                   sel;
		logic [IDX_W-1:0]                   idx;
		logic [DATA_W-1:0]                  val;
		logic                               present;
	} q_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  mapped_value;
		logic               status;
		logic [STEP_W-1:0]  answering_step;
	} res_t;

	function automatic int stage_limit(input int hs);
		return (hs < STAGE_REGS) ? hs : STAGE_REGS;
	endfunction

	// one slice of the reflected crc: shift right, xor poly when a one drops out
	function automatic logic [KEY_W-1:0] crc_rounds(input logic [KEY_W-1:0] c_in,
			input logic [KEY_W-1:0] poly);
		logic [KEY_W-1:0] c;
		c = c_in;
		for (int r = 0; r < CRC_STEP_ROUNDS; r++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/chcl_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcl_in_if
// Item channel: lookups and table writes with valid/ready handshake.
// ----------------------------------------------------------------------------
interface chcl_in_if;
	import chcl_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [KEY_W-1:0]   lookup_key;
	logic [SEL_W-1:0]   table_select;
	logic [IDX_W-1:0]   entry_index;
	logic [DATA_W-1:0]  entry_value;
	logic               entry_present;

	modport source (
		output valid, kind, lookup_key, table_select, entry_index, entry_value,
			entry_present,
		input  ready
	);

	modport sink (
		input  valid, kind, lookup_key, table_select, entry_index, entry_value,
			entry_present,
		output ready
	);

endinterface
`default_nettype wire

FILE: rtl/chcl_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcl_out_if
// Result channel: mapped value, status and answering step.
// ----------------------------------------------------------------------------
interface chcl_out_if;
	import chcl_pkg::*;

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  mapped_value;
	logic               status;
	logic [STEP_W-1:0]  answering_step;

	modport source (
		output valid, mapped_value, status, answering_step,
		input  ready
	);

	modport sink (
		input  valid, mapped_value, status, answering_step,
		output ready
	);

endinterface
`default_nettype wire

FILE: rtl/crc_hashed_table_lookup_chain_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_hashed_table_lookup_chain_unit
// Maps a 32-bit key to a value through CRC-hashed stage tables and a final
// table; table contents are loaded by write items on the same channel.
// ----------------------------------------------------------------------------
// After reset the block sweeps every table entry invalid, one entry per
// cycle, so the item channel stays not-ready until the sweep is done
// (configuration writes are taken meanwhile). It then accepts one item per
// cycle as long as results are taken: the three key CRCs run in a four-stage
// pipeline of eight rounds each, a four-entry queue decouples this front
// from the back end, and the back end reads all tables at once through one
// read port each, and a lookup result leaves through an output queue.
// Table writes give no result and update in item order with the lookups.
// ----------------------------------------------------------------------------
module crc_hashed_table_lookup_chain_unit #(
	parameter int TABLE_DEPTH = chcl_pkg::TABLE_DEPTH_DEF,
	parameter int HASH_STAGES = chcl_pkg::HASH_STAGES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [chcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [chcl_pkg::CFG_DATA_W-1:0]  cfg_data,
	chcl_in_if.sink                               item,
	chcl_out_if.source                            result
);
	import chcl_pkg::*;

	cfg_t                      cfg_q;
	logic                      q_push;
	q_item_t                   q_din;
	logic                      q_full;
	logic                      q_pop;
	logic                      q_valid;
	logic [$bits(q_item_t)-1:0] q_dout;
	logic [$clog2(ITEM_Q_DEPTH+1)-1:0] q_count;
	logic                      clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STAGE_COUNT: cfg_q.stage_count       <= cfg_data[COUNT_W-1:0];
				REG_STAGE0_POLY: cfg_q.stage_poly[0]     <= cfg_data;
				REG_STAGE1_POLY: cfg_q.stage_poly[1]     <= cfg_data;
				REG_STAGE0_SENT: cfg_q.stage_sentinel[0] <= cfg_data;
				REG_STAGE1_SENT: cfg_q.stage_sentinel[1] <= cfg_data;
				REG_PLAIN_EN:    cfg_q.plain_en          <= cfg_data[0];
				REG_PLAIN_POLY:  cfg_q.plain_poly        <= cfg_data;
				default: ;
			endcase
		end
	end

	chcl_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.HASH_STAGES (HASH_STAGES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.hold   (clr_busy),
		.item   (item),
		.q_push (q_push),
		.q_data (q_din),
		.q_full (q_full)
	);

	chcl_fifo #(
		.WIDTH ($bits(q_item_t)),
		.DEPTH (ITEM_Q_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid),
		.full   (q_full),
		.count  (q_count)
	);

	chcl_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.HASH_STAGES (HASH_STAGES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_data   (q_item_t'(q_dout)),
		.q_pop    (q_pop),
		.clr_busy (clr_busy),
		.result   (result)
	);

`ifndef SYNTH
	// no item may enter while the tables are being swept
	a_clr_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !item.ready)
		else $error("item channel ready during table clearing");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("front pushed into a full item queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && (q_count != '0)))
		else $error("back popped an empty item queue");

	a_clr_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !q_pop)
		else $error("back consumed an item during table clearing");
`endif

endmodule
`default_nettype wire

FILE: rtl/chcl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chcl_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/chcl_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcl_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module chcl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [WIDTH-1:0]            din,
	input  wire logic                        pop,
	output logic      [WIDTH-1:0]            dout,
	output logic                             valid,
	output logic                             full,
	output logic      [$clog2(DEPTH+1)-1:0]  count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign valid   = (count_q != '0);
	assign full    = (count_q == FULL_CNT);
	assign count   = count_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/chcl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcl_front
// Accepts items, runs the three key CRCs through a four-stage pipeline of
// eight rounds each, and classifies the item for the back end.
// ----------------------------------------------------------------------------
module chcl_front #(
	parameter int TABLE_DEPTH = chcl_pkg::TABLE_DEPTH_DEF,
	parameter int HASH_STAGES = chcl_pkg::HASH_STAGES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire chcl_pkg::cfg_t   cfg,
	input  wire logic             hold,
	chcl_in_if.sink               item,
	output logic                  q_push,
	output chcl_pkg::q_item_t     q_data,
	input  wire logic             q_full
);
	import chcl_pkg::*;

	localparam int NSTG = stage_limit(HASH_STAGES);
	localparam logic [KEY_W-1:0] DEPTH_V = KEY_W'(TABLE_DEPTH);

	logic                             en;
	logic                             acc;
	logic [NUM_CRC-1:0][KEY_W-1:0]    poly;
	logic                             vld_s1, vld_s2, vld_s3, vld_s4;
	in_item_t                         item_s1, item_s2, item_s3, item_s4;
	logic [NUM_CRC-1:0][KEY_W-1:0]    crc_s1, crc_s2, crc_s3, crc_s4;
	logic [NUM_CRC-1:0][KEY_W-1:0]    hash;
	logic [KEY_W-1:0]                 idx32;

	// pipeline moves whenever the last stage can leave
	assign en         = !vld_s4 || !q_full;
	assign item.ready = en && !hold;
	assign acc        = item.valid && item.ready;
	assign q_push     = vld_s4 && !q_full;

	always_comb begin
		for (int k = 0; k < STAGE_REGS; k++) begin
			poly[k] = cfg.stage_poly[k];
		end
		poly[CRC_PLAIN] = cfg.plain_poly;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= '{kind: item.kind, key: item.lookup_key, sel: item.table_select,
				idx: item.entry_index, val: item.entry_value, present: item.entry_present};
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			for (int k = 0; k < NUM_CRC; k++) begin
				crc_s1[k] <= crc_rounds(item.lookup_key, poly[k]);
				crc_s2[k] <= crc_rounds(crc_s1[k], poly[k]);
				crc_s3[k] <= crc_rounds(crc_s2[k], poly[k]);
				crc_s4[k] <= crc_rounds(crc_s3[k], poly[k]);
			end
		end
	end

	// final xor and range checks
	always_comb begin
		for (int k = 0; k < NUM_CRC; k++) begin
			hash[k] = crc_s4[k] ^ poly[k];
		end
		idx32           = KEY_W'(item_s4.idx);
		q_data.kind     = item_s4.kind;
		for (int k = 0; k < STAGE_REGS; k++) begin
			q_data.hash[k]     = hash[k];
			q_data.hash_oor[k] = (hash[k] >= DEPTH_V);
		end
		q_data.fkey     = cfg.plain_en ? hash[CRC_PLAIN] : item_s4.key;
		q_data.fkey_oor = (q_data.fkey >= DEPTH_V);
		q_data.wr_ok    = (item_s4.kind == KIND_WRITE) && (idx32 < DEPTH_V) &&
			((item_s4.sel == SEL_FINAL) || (32'(item_s4.sel) < 32'(NSTG)));
		q_data.sel      = item_s4.sel;
		q_data.idx      = item_s4.idx;
		q_data.val      = item_s4.val;
		q_data.present  = item_s4.present;
	end

endmodule
`default_nettype wire

FILE: rtl/chcl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chcl_back
// Owns the stage and final tables: clears them after reset, applies table
// writes, reads all tables for a lookup at once and picks the answer.
// ----------------------------------------------------------------------------
module chcl_back #(
	parameter int TABLE_DEPTH = chcl_pkg::TABLE_DEPTH_DEF,
	parameter int HASH_STAGES = chcl_pkg::HASH_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire chcl_pkg::cfg_t     cfg,
	input  wire logic               q_valid,
	input  wire chcl_pkg::q_item_t  q_data,
	output logic                    q_pop,
	output logic                    clr_busy,
	chcl_out_if.source              result
);
	import chcl_pkg::*;

	localparam int NSTG  = stage_limit(HASH_STAGES);
	localparam int IW    = $clog2(TABLE_DEPTH);
	localparam int ENT_W = DATA_W + 1;
	localparam int OCW   = $clog2(OUT_Q_DEPTH + 1);
	localparam logic [IW-1:0]      LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam logic [COUNT_W-1:0] NSTG_V   = COUNT_W'(NSTG);

	logic                           clr_busy_q;
	logic [IW-1:0]                  clr_cnt_q;
	logic                           is_wr;
	logic                           credit_ok;
	logic [OCW:0]                   used;
	logic                           rd_en;
	logic                           wr_en;
	logic [KEY_W-1:0]               idx32;
	logic [IW-1:0]                  waddr;
	logic [ENT_W-1:0]               wdata;
	logic [NSTG-1:0][ENT_W-1:0]     st_rdata;
	logic [ENT_W-1:0]               fin_rdata;
	logic                           rd_vld_s1;
	logic [STAGE_REGS-1:0]          oor_s1;
	logic                           foor_s1;
	logic [COUNT_W-1:0]             n_use;
	res_t                           res;
	logic                           done;
	logic                           out_pop;
	logic [$bits(res_t)-1:0]        out_dout;
	logic                           out_full;
	logic [OCW-1:0]                 out_count;
	res_t                           out_res;

	assign clr_busy = clr_busy_q;
	assign is_wr    = (q_data.kind == KIND_WRITE);

	// a lookup may go only if its result is sure of a slot in the output queue
	assign used      = (OCW+1)'(out_count) + (OCW+1)'(rd_vld_s1);
	assign credit_ok = used <= ((OCW+1)'(OUT_Q_DEPTH - 1) + (OCW+1)'(out_pop));
	assign q_pop     = q_valid && !clr_busy_q && (is_wr || credit_ok);
	assign rd_en     = q_pop && !is_wr;
	assign wr_en     = q_pop && is_wr && q_data.wr_ok;

	assign idx32 = KEY_W'(q_data.idx);
	assign waddr = clr_busy_q ? clr_cnt_q : idx32[IW-1:0];
	assign wdata = clr_busy_q ? '0 : {q_data.present, q_data.val};

	// clearing pass over every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	for (genvar s = 0; s < NSTG; s++) begin : g_stage
		chcl_ram #(
			.WIDTH (ENT_W),
			.DEPTH (TABLE_DEPTH)
		) u_stage_ram (
			.clk   (clk),
			.we    (clr_busy_q || (wr_en && (q_data.sel == SEL_W'(s)))),
			.waddr (waddr),
			.wdata (wdata),
			.re    (rd_en),
			.raddr (q_data.hash[s][IW-1:0]),
			.rdata (st_rdata[s])
		);
	end

	chcl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_final_ram (
		.clk   (clk),
		.we    (clr_busy_q || (wr_en && (q_data.sel == SEL_FINAL))),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (q_data.fkey[IW-1:0]),
		.rdata (fin_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			oor_s1  <= q_data.hash_oor;
			foor_s1 <= q_data.fkey_oor;
		end
	end

	// walk the stages in order: miss stops, non-sentinel answers, sentinel goes on; the final table answers last
	always_comb begin
		n_use = (cfg.stage_count > NSTG_V) ? NSTG_V : cfg.stage_count;
		done  = 1'b0;
		res   = '{mapped_value: '0, status: STATUS_MISS, answering_step: STEP_FINAL};
		for (int s = 0; s < NSTG; s++) begin
			if (!done && (COUNT_W'(s) < n_use)) begin
				if (oor_s1[s] || !st_rdata[s][DATA_W]) begin
					res  = '{mapped_value: '0, status: STATUS_MISS,
						answering_step: STEP_W'(s)};
					done = 1'b1;
				end else if (st_rdata[s][DATA_W-1:0] != cfg.stage_sentinel[s]) begin
					res  = '{mapped_value: st_rdata[s][DATA_W-1:0], status: STATUS_FOUND,
						answering_step: STEP_W'(s)};
					done = 1'b1;
				end
			end
		end
		if (!done && !foor_s1 && fin_rdata[DATA_W]) begin
			res = '{mapped_value: fin_rdata[DATA_W-1:0], status: STATUS_FOUND,
				answering_step: STEP_FINAL};
		end
	end

	chcl_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_Q_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rd_vld_s1),
		.din    (res),
		.pop    (out_pop),
		.dout   (out_dout),
		.valid  (result.valid),
		.full   (out_full),
		.count  (out_count)
	);

	assign out_pop               = result.valid && result.ready;
	assign out_res               = res_t'(out_dout);
	assign result.mapped_value   = out_res.mapped_value;
	assign result.status         = out_res.status;
	assign result.answering_step = out_res.answering_step;

endmodule
`default_nettype wire
